// File: hw/rtl/sagk_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sagk_pkg
// Shared types, tap sets and register-clocking functions of the
// stop-and-go keystream cipher.
// ---------------------------------------------------------------------------
package sagk_pkg;

   localparam int unsigned REG_W  = 64;
   localparam int unsigned BYTE_W = 8;

   typedef logic [REG_W-1:0]  reg_word_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic [5:0] a;
      logic [5:0] b;
      logic [5:0] c;
      logic [5:0] d;
      logic [5:0] e;
   } tap_set_type;

   // Generator state: the three registers and the two carried bits
   typedef struct packed {
      reg_word_type ctrl;
      reg_word_type stepped;
      reg_word_type steady;
      logic         last_ctrl;
      logic         stepped_out;
   } gen_state_type;

   localparam tap_set_type CTRL_TAPS    = '{a: 6'd31, b: 6'd7,  c: 6'd9,  d: 6'd1,  e: 6'd0};
   localparam tap_set_type STEPPED_TAPS = '{a: 6'd31, b: 6'd27, c: 6'd9,  d: 6'd21, e: 6'd0};
   localparam tap_set_type STEADY_TAPS  = '{a: 6'd31, b: 6'd8,  c: 6'd19, d: 6'd10, e: 6'd3};

   localparam reg_word_type CTRL_ADD    = 64'h0000_0000_0111_1111;
   localparam reg_word_type STEPPED_ADD = 64'h0000_0000_0222_2222;
   localparam reg_word_type STEADY_ADD  = 64'h0000_0000_0333_3333;

   // One clock step: feedback lands on bit 31, ORed with the shifted word
   function automatic reg_word_type lfsr_clock(input reg_word_type v, input tap_set_type tp);
      logic         t;
      reg_word_type r;
      t     = v[tp.a] ^ v[tp.b] ^ v[tp.c] ^ v[tp.d] ^ v[tp.e] ^ v[0];
      r     = v >> 1;
      r[31] = r[31] | t;
      return r;
   endfunction

   function automatic reg_word_type seed_mix(input reg_word_type key, input reg_word_type add,
                                             input int unsigned lsh, input int unsigned rsh);
      reg_word_type s;
      s = key + add;
      return ((s << lsh) ^ (s >> rsh)) ^ key;
   endfunction

   // Seed all registers from the key and clock each once
   function automatic gen_state_type key_load(input reg_word_type key);
      gen_state_type g;
      g.ctrl        = lfsr_clock(seed_mix(key, CTRL_ADD, 13, 19), CTRL_TAPS);
      g.stepped     = lfsr_clock(seed_mix(key, STEPPED_ADD, 17, 15), STEPPED_TAPS);
      g.steady      = lfsr_clock(seed_mix(key, STEADY_ADD, 19, 13), STEADY_TAPS);
      g.last_ctrl   = g.ctrl[0];
      g.stepped_out = g.stepped[0];
      return g;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sagk_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sagk_req_if
// Request channel: one data byte and its restart flag.
// ---------------------------------------------------------------------------
interface sagk_req_if;
   logic              valid;
   logic              ready;
   sagk_pkg::byte_type data_byte;
   logic              first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sagk_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sagk_rsp_if
// Response channel: one ciphered byte.
// ---------------------------------------------------------------------------
interface sagk_rsp_if;
   logic              valid;
   logic              ready;
   sagk_pkg::byte_type out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sagk_key_sched.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sagk_key_sched
// Key register: holds the generator start state derived from the key.
// ---------------------------------------------------------------------------
module sagk_key_sched (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire sagk_pkg::reg_word_type  csr_wr_data,
   output sagk_pkg::gen_state_type      sched
);

   sagk_pkg::gen_state_type sched_ff;
   sagk_pkg::gen_state_type sched_in;

   // Precompute the seeded and once-clocked state at write time
   assign sched_in = sagk_pkg::key_load(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         sched_ff <= sagk_pkg::key_load('0);
      end else if (csr_wr_en) begin
         sched_ff <= sched_in;
      end
   end

   assign sched = sched_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sagk_gen.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sagk_gen
// Keystream generator: state registers and eight unrolled clock steps.
// ---------------------------------------------------------------------------
module sagk_gen (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic                    first_byte,
   input  wire sagk_pkg::gen_state_type sched,
   output sagk_pkg::byte_type           ks_byte,
   output logic                         all_zero
);

   sagk_pkg::gen_state_type state_ff;
   sagk_pkg::gen_state_type state_in;
   sagk_pkg::gen_state_type start;
   sagk_pkg::reg_word_type  ctrl_w;
   sagk_pkg::reg_word_type  stepped_w;
   sagk_pkg::reg_word_type  steady_w;
   logic                    lcb;
   logic                    sob;
   sagk_pkg::byte_type      ks;

   assign start = first_byte ? sched : state_ff;

   always_comb begin
      ctrl_w    = start.ctrl;
      stepped_w = start.stepped;
      steady_w  = start.steady;
      lcb       = start.last_ctrl;
      sob       = start.stepped_out;
      ks        = '0;
      for (int i = 0; i < sagk_pkg::BYTE_W; i++) begin
         ctrl_w = sagk_pkg::lfsr_clock(ctrl_w, sagk_pkg::CTRL_TAPS);
         // advance the stepped register only behind a control one
         if (lcb) begin
            stepped_w = sagk_pkg::lfsr_clock(stepped_w, sagk_pkg::STEPPED_TAPS);
            sob       = stepped_w[0];
         end
         steady_w = sagk_pkg::lfsr_clock(steady_w, sagk_pkg::STEADY_TAPS);
         ks[3'(sagk_pkg::BYTE_W - 1 - i)] = sob ^ steady_w[0];
         lcb = ctrl_w[0];
      end
      state_in.ctrl        = ctrl_w;
      state_in.stepped     = stepped_w;
      state_in.steady      = steady_w;
      state_in.last_ctrl   = lcb;
      state_in.stepped_out = sob;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   assign ks_byte  = ks;
   assign all_zero = (state_ff == '0);

endmodule
`default_nettype wire

// File: hw/rtl/stop_and_go_keystream_cipher_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stop_and_go_keystream_cipher_top
// Byte stream cipher driven by a stop-and-go generator of three shift
// registers; encryption and decryption are the same operation.
// ---------------------------------------------------------------------------
// Usage: write the 64-bit key through csr_wr_en/csr_wr_data while no request
// is in flight, then send a request with first_byte set to restart the
// generator from that key; later bytes carry first_byte clear and continue the
// keystream. Each request returns exactly one response, out_byte, the data
// byte XORed with eight keystream bits, first bit in the MSB. The block takes
// one request per cycle while the response side is not stalled: the request
// is registered, then the eight generator steps for the byte run as one pass
// of logic into the response register, which also writes the new generator
// state back. That single pass per byte sets the rate. The seeded
// start state is worked out when the key is written, so a restart costs
// nothing extra. A new key acts only at the next request with first_byte set.
// Without any restart the generator sits in the all-zero state and passes
// bytes through unchanged.
// ---------------------------------------------------------------------------
module stop_and_go_keystream_cipher_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   sagk_req_if.sink                     req_chan,
   sagk_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_wr_en,
   input  wire sagk_pkg::reg_word_type  csr_wr_data
);

   // request register
   logic               s1_valid_ff;
   logic               s1_valid_in;
   sagk_pkg::byte_type s1_data_ff;
   logic               s1_first_ff;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   sagk_pkg::byte_type rsp_byte_ff;

   logic                    req_take;
   logic                    out_free;
   logic                    gen_fire;
   sagk_pkg::gen_state_type sched;
   sagk_pkg::byte_type      ks_byte;
   logic                    gen_zero;

   // The response register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign gen_fire = s1_valid_ff && out_free;

   // Take a new request whenever the held one moves on
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (gen_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = gen_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff  <= req_chan.data_byte;
         s1_first_ff <= req_chan.first_byte;
      end
      if (gen_fire) begin
         rsp_byte_ff <= s1_data_ff ^ ks_byte;
      end
   end

   sagk_key_sched u_key_sched (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .sched       (sched)
   );

   sagk_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .fire       (gen_fire),
      .first_byte (s1_first_ff),
      .sched      (sched),
      .ks_byte    (ks_byte),
      .all_zero   (gen_zero)
   );

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;

   // A request that advances always shows up as a response next cycle
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      gen_fire |=> rsp_chan.valid)
      else $error("advanced request did not reach the response register");

   // A held request blocks the input while the response side is stalled
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_chan.ready)
      else $error("request accepted over a stalled one");

   // From the all-zero state without a restart the byte passes unchanged
   a_zero_pass: assert property (@(posedge clock) disable iff (reset)
      (gen_fire && !s1_first_ff && gen_zero) |=> (rsp_chan.out_byte == $past(s1_data_ff)))
      else $error("all-zero generator altered a byte");

endmodule
`default_nettype wire
